// ===== rtl/smrp_pkg.sv =====
package smrp_pkg;

  localparam logic KIND_MOVE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  localparam logic [1:0] REG_STEPS_PER_REV = 2'd0;
  localparam logic [1:0] REG_MAX_DELAY     = 2'd1;
  localparam logic [1:0] REG_MIN_DELAY     = 2'd2;
  localparam logic [1:0] REG_RAMP_MODE     = 2'd3;

  localparam logic [1:0] MODE_CONSTANT = 2'd0;
  localparam logic [1:0] MODE_LINEAR   = 2'd1;
  localparam logic [1:0] MODE_SINE     = 2'd2;
  localparam logic [1:0] MODE_SPARE    = 2'd3;

  localparam logic [15:0] RESET_STEPS_PER_REV = 16'd6400;
  localparam logic [15:0] RESET_MAX_DELAY     = 16'd1000;
  localparam logic [15:0] RESET_MIN_DELAY     = 16'd200;
  localparam logic [1:0]  RESET_RAMP_MODE     = 2'd0;

  typedef struct packed {
    logic capture;
    logic apply_move;
    logic tick_dec;
    logic go_low;
    logic step_end;
    logic step_next;
    logic div_start;
    logic sine_lut;
    logic sine_mul;
    logic load_delay;
  } cmd_t;

  typedef struct packed {
    logic moving;
    logic pulse;
    logic delay_gt1;
    logic last_step;
    logic move_zero;
    logic use_div;
    logic sine_mode;
    logic div_busy;
  } status_t;

endpackage

// ===== rtl/smrp_div.sv =====
module smrp_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic        busy,
  output logic [31:0] quotient
);

  logic [31:0] quo;
  logic [15:0] rem;
  logic [5:0]  cnt;
  logic        run;
  logic [16:0] trial;
  logic [16:0] diff;
  logic        ge;

  assign trial = {rem, quo[31]};
  assign diff  = trial - {1'b0, divisor};
  assign ge    = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      run <= 1'b1;
      cnt <= 6'd32;
    end else if (run) begin
      cnt <= cnt - 6'd1;
      if (cnt == 6'd1) begin
        run <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (run) begin
      quo <= {quo[30:0], ge};
      rem <= ge ? diff[15:0] : trial[15:0];
    end
  end

  assign busy     = run;
  assign quotient = quo;

endmodule

// ===== rtl/smrp_dp.sv =====
module smrp_dp #(
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             write_en,
  input  logic [1:0]       write_index,
  input  logic [15:0]      write_data,
  input  logic [15:0]      target_fraction,
  input  smrp_pkg::cmd_t   cmd,
  output smrp_pkg::status_t status,
  output logic             pulse_level,
  output logic             direction_level,
  output logic             enable_level,
  output logic             busy_res,
  output logic [15:0]      position
);
  import smrp_pkg::*;

  localparam int TabN = SINE_TABLE_DEPTH + 1;
  localparam int PW   = $clog2(2 * SINE_TABLE_DEPTH);
  localparam int TW   = $clog2(SINE_TABLE_DEPTH + 1);
  localparam longint unsigned HalfPiQ30 = 64'd1686629713;
  localparam longint unsigned TaylorDiv [8] =
    '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272};

  typedef logic [14:0] tab_t [TabN];

  function automatic tab_t build_tab();
    tab_t tab;
    longint unsigned x;
    longint unsigned term;
    longint sum;
    longint r;
    for (int k = 0; k < TabN; k++) begin
      x = (HalfPiQ30 * longint'(k)) / SINE_TABLE_DEPTH;
      term = x;
      sum = longint'(x);
      for (int n = 1; n <= 8; n++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / TaylorDiv[n-1];
        if (n % 2 == 1) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      r = (sum + 64'sd16384) >>> 15;
      if (r > 32767) r = 32767;
      tab[k] = r[14:0];
    end
    return tab;
  endfunction

  localparam tab_t SineTab = build_tab();

  function automatic logic [15:0] clamp_delay(input logic signed [17:0] d);
    logic [15:0] res;
    if (d < 18'sd1) res = 16'd1;
    else if (d > 18'sd65535) res = 16'hFFFF;
    else res = d[15:0];
    return res;
  endfunction

  logic [15:0] steps_per_rev, slow_delay, fast_delay;
  logic [1:0]  ramp_mode;
  logic [15:0] step_position, total_steps, step_index, delay_left;
  logic        pulse_state, dir_state, enable_state, moving;
  logic [31:0] tgt_prod;
  logic [14:0] sine_val;
  logic signed [32:0] sine_prod;

  // move
  logic [15:0]        target;
  logic signed [17:0] diff, h_s, spr_s, adj, adj_mag;
  logic [16:0]        half_rev, half_rev_nz;
  logic [15:0]        move_total;

  assign target      = tgt_prod[31:16];
  assign diff        = $signed({2'b00, target}) - $signed({2'b00, step_position});
  assign half_rev    = ({1'b0, steps_per_rev} + 17'd1) >> 1;
  assign half_rev_nz = (half_rev == 17'd0) ? 17'd1 : half_rev;
  assign h_s         = $signed({1'b0, half_rev_nz});
  assign spr_s       = $signed({2'b00, steps_per_rev});

  always_comb begin
    if (diff <= -h_s) adj = diff + spr_s;
    else if (diff >= h_s) adj = diff - spr_s;
    else adj = diff;
  end

  assign adj_mag    = (adj < 0) ? -adj : adj;
  assign move_total = adj_mag[15:0];

  // tick
  logic [16:0] next_index;
  assign next_index = {1'b0, step_index} + 17'd1;

  // linear ramp
  logic [15:0]        half, j, m, mag, lin_q, base;
  logic               first, tail, neg;
  logic signed [17:0] delta, lin_d;

  assign half  = {1'b0, total_steps[15:1]};
  assign first = step_index < half;
  assign j     = step_index - half;
  assign tail  = !first && (j >= half);
  assign m     = first ? step_index : j;
  assign delta = first ? ($signed({2'b00, fast_delay}) - $signed({2'b00, slow_delay}))
                       : ($signed({2'b00, slow_delay}) - $signed({2'b00, fast_delay}));
  assign neg   = delta < 0;
  assign mag   = neg ? 16'(-delta) : delta[15:0];
  assign base  = first ? slow_delay : fast_delay;

  // divider
  logic [31:0] dividend, div_quo;
  logic [15:0] divisor;
  logic        div_busy;

  assign dividend = (ramp_mode == MODE_SINE)
                  ? 32'(step_index) * 32'(2 * SINE_TABLE_DEPTH)
                  : 32'(mag) * 32'(m);
  assign divisor  = (ramp_mode == MODE_SINE) ? total_steps : half;

  smrp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  assign lin_q = div_quo[15:0];
  assign lin_d = $signed({2'b00, base})
               + (neg ? -$signed({2'b00, lin_q}) : $signed({2'b00, lin_q}));

  // sine ramp
  logic [PW-1:0]      p, mirror;
  logic signed [17:0] diff_mm, sin_d;
  logic signed [32:0] sp_adj, sp_shift;

  assign p       = div_quo[PW-1:0];
  assign mirror  = (p <= PW'(SINE_TABLE_DEPTH)) ? p : PW'(2 * SINE_TABLE_DEPTH) - p;
  assign diff_mm = $signed({2'b00, slow_delay}) - $signed({2'b00, fast_delay});
  assign sp_adj  = (sine_prod < 0) ? sine_prod + 33'sd32767 : sine_prod;
  assign sp_shift = sp_adj >>> 15;
  assign sin_d   = $signed({2'b00, slow_delay}) - $signed(sp_shift[17:0]);

  logic [15:0] d_new;
  always_comb begin
    case (ramp_mode)
      MODE_LINEAR: d_new = tail ? clamp_delay($signed({2'b00, slow_delay}))
                                : clamp_delay(lin_d);
      MODE_SINE:   d_new = clamp_delay(sin_d);
      default:     d_new = clamp_delay($signed({2'b00, slow_delay}));
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      steps_per_rev <= RESET_STEPS_PER_REV;
      slow_delay    <= RESET_MAX_DELAY;
      fast_delay    <= RESET_MIN_DELAY;
      ramp_mode     <= RESET_RAMP_MODE;
    end else if (write_en) begin
      unique case (write_index)
        REG_STEPS_PER_REV: steps_per_rev <= write_data;
        REG_MAX_DELAY:     slow_delay    <= write_data;
        REG_MIN_DELAY:     fast_delay    <= write_data;
        REG_RAMP_MODE:     ramp_mode     <= write_data[1:0];
        default:           ramp_mode     <= ramp_mode;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_position <= '0;
      total_steps   <= '0;
      step_index    <= '0;
      delay_left    <= '0;
      pulse_state   <= 1'b0;
      dir_state     <= 1'b0;
      enable_state  <= 1'b0;
      moving        <= 1'b0;
    end else begin
      if (cmd.apply_move) begin
        step_position <= target;
        dir_state     <= (adj > 0) ? 1'b0 : 1'b1;
        enable_state  <= 1'b1;
        total_steps   <= move_total;
        step_index    <= '0;
        moving        <= move_total != 16'd0;
        pulse_state   <= move_total != 16'd0;
        delay_left    <= '0;
      end
      if (cmd.tick_dec) begin
        delay_left <= delay_left - 16'd1;
      end
      if (cmd.go_low) begin
        pulse_state <= 1'b0;
      end
      if (cmd.step_end) begin
        step_index <= next_index[15:0];
        moving     <= 1'b0;
        delay_left <= '0;
      end
      if (cmd.step_next) begin
        step_index  <= next_index[15:0];
        pulse_state <= 1'b1;
      end
      if (cmd.load_delay) begin
        delay_left <= d_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      tgt_prod <= 32'(target_fraction) * 32'(steps_per_rev);
    end
    if (cmd.sine_lut) begin
      sine_val <= SineTab[mirror[TW-1:0]];
    end
    if (cmd.sine_mul) begin
      sine_prod <= diff_mm * $signed({1'b0, sine_val});
    end
  end

  always_comb begin
    status.moving    = moving;
    status.pulse     = pulse_state;
    status.delay_gt1 = delay_left > 16'd1;
    status.last_step = next_index >= {1'b0, total_steps};
    status.move_zero = move_total == 16'd0;
    status.use_div   = (ramp_mode == MODE_LINEAR) || (ramp_mode == MODE_SINE);
    status.sine_mode = ramp_mode == MODE_SINE;
    status.div_busy  = div_busy;
  end

  assign pulse_level     = pulse_state;
  assign direction_level = dir_state;
  assign enable_level    = enable_state;
  assign busy_res        = moving;
  assign position        = step_position;

endmodule

// ===== rtl/smrp_ctrl.sv =====
module smrp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              kind,
  output logic              out_valid,
  input  logic              out_stall,
  input  smrp_pkg::status_t status,
  output smrp_pkg::cmd_t    cmd
);
  import smrp_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_TGT  = 3'd1;
  localparam logic [2:0] S_CALC = 3'd2;
  localparam logic [2:0] S_DIVW = 3'd3;
  localparam logic [2:0] S_SLUT = 3'd4;
  localparam logic [2:0] S_SMUL = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0] state, state_next;
  logic       accept, out_set;

  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cmd        = '0;
    out_set    = 1'b0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (kind == KIND_MOVE) begin
            if (status.moving) begin
              out_set = 1'b1;
            end else begin
              cmd.capture = 1'b1;
              state_next  = S_TGT;
            end
          end else if (!status.moving) begin
            out_set = 1'b1;
          end else if (status.delay_gt1) begin
            cmd.tick_dec = 1'b1;
            out_set      = 1'b1;
          end else if (status.pulse) begin
            cmd.go_low = 1'b1;
            state_next = S_CALC;
          end else if (status.last_step) begin
            cmd.step_end = 1'b1;
            out_set      = 1'b1;
          end else begin
            cmd.step_next = 1'b1;
            state_next    = S_CALC;
          end
        end
      end
      S_TGT: begin
        cmd.apply_move = 1'b1;
        if (status.move_zero) begin
          out_set    = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_CALC;
        end
      end
      S_CALC: begin
        if (status.use_div) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIVW;
        end else begin
          state_next = S_FIN;
        end
      end
      S_DIVW: begin
        if (!status.div_busy) begin
          state_next = status.sine_mode ? S_SLUT : S_FIN;
        end
      end
      S_SLUT: begin
        cmd.sine_lut = 1'b1;
        state_next   = S_SMUL;
      end
      S_SMUL: begin
        cmd.sine_mul = 1'b1;
        state_next   = S_FIN;
      end
      S_FIN: begin
        cmd.load_delay = 1'b1;
        out_set        = 1'b1;
        state_next     = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_set || (out_valid && out_stall);
    end
  end

endmodule

// ===== rtl/stepper_move_ramp_pulser_core.sv =====
// channel  | handshake                     | payload
// request  | in_valid / in_stall           | kind, target_fraction
// result   | out_valid / out_stall         | pulse_level, direction_level, enable_level,
//          |                               | busy_res, position
// config   | write_en                      | write_index, write_data
//
// a tick inside a half-period, a tick ending the last step, an idle request and
// a move while busy are answered from the idle state; a zero-length move after
// the target state; any other move after a new step delay
// a tick ending a high half or starting the next step takes a new step delay:
// direct at constant speed, the divider if linear, divider/table/multiply if sine
// synchronous reset clears all motion state and loads the register defaults
// a result held by out_stall holds off the next request until it is taken
module stepper_move_ramp_pulser_core #(
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        write_en,
  input  logic [1:0]  write_index,
  input  logic [15:0] write_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        kind,
  input  logic [15:0] target_fraction,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        pulse_level,
  output logic        direction_level,
  output logic        enable_level,
  output logic        busy_res,
  output logic [15:0] position
);
  import smrp_pkg::*;

  cmd_t    cmd;
  status_t status;

  smrp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  smrp_dp #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .write_en        (write_en),
    .write_index     (write_index),
    .write_data      (write_data),
    .target_fraction (target_fraction),
    .cmd             (cmd),
    .status          (status),
    .pulse_level     (pulse_level),
    .direction_level (direction_level),
    .enable_level    (enable_level),
    .busy_res        (busy_res),
    .position        (position)
  );

  a_hold_in: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> in_stall)
    else $error("request taken while result held");

  a_idle_low: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !busy_res) |-> !pulse_level)
    else $error("pulse high with no move running");

  a_start_high: assert property (@(posedge clk) disable iff (rst)
    $rose(busy_res) |-> (pulse_level && enable_level))
    else $error("move started without pulse and enable");

endmodule

// ===== test/stepper_move_ramp_pulser_checker.sv =====
module stepper_move_ramp_pulser_checker #(
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        write_en,
  input  logic [1:0]  write_index,
  input  logic [15:0] write_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        kind,
  input  logic [15:0] target_fraction,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        pulse_level,
  input  logic        direction_level,
  input  logic        enable_level,
  input  logic        busy_res,
  input  logic [15:0] position,
  output int          fail_count,
  output int          pending_results,
  output logic        motion_active
);
  timeunit 1ns;
  timeprecision 1ps;
  import smrp_pkg::*;

  typedef struct packed {
    logic        pulse;
    logic        dir;
    logic        en;
    logic        busy;
    logic [15:0] pos;
  } motor_state_t;

  motor_state_t expected_states[$];

  logic [15:0] cfg_spr, cfg_max, cfg_min;
  logic [1:0]  cfg_mode;
  logic [15:0] pos_q, total_q, index_q, half_ticks, ticks_left;
  logic        pulse_q, dir_q, en_q, moving_q;
  int          sine_q15[0:SINE_TABLE_DEPTH];

  function automatic int sine_point(int k);
    longint unsigned x, term;
    longint          sum, r;
    x = (64'd1686629713 * longint'(k)) / longint'(SINE_TABLE_DEPTH);
    term = x;
    sum = longint'(x);
    for (int n = 1; n <= 8; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    r = (sum + 16384) / 32768;
    if (r > 32767) r = 32767;
    return int'(r);
  endfunction

  initial begin
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) sine_q15[k] = sine_point(k);
  end

  function automatic logic [15:0] bound_delay(longint d);
    if (d < 1) return 16'd1;
    if (d > 65535) return 16'hffff;
    return d[15:0];
  endfunction

  function automatic logic [15:0] step_delay(logic [15:0] i);
    longint mx, mn, half, p, s, tot;
    mx = longint'(cfg_max);
    mn = longint'(cfg_min);
    tot = longint'(total_q);
    if (cfg_mode == MODE_LINEAR) begin
      half = tot / 2;
      if (longint'(i) < half) return bound_delay(mx + (longint'(i) * (mn - mx)) / half);
      if (longint'(i) - half < half)
        return bound_delay(mn + ((longint'(i) - half) * (mx - mn)) / half);
      return bound_delay(mx);
    end
    if (cfg_mode == MODE_SINE && tot != 0) begin
      p = (longint'(i) * 2 * SINE_TABLE_DEPTH) / tot;
      if (p <= SINE_TABLE_DEPTH) s = sine_q15[p];
      else if (p < 2 * SINE_TABLE_DEPTH) s = sine_q15[2 * SINE_TABLE_DEPTH - p];
      else s = 0;
      return bound_delay(mx - ((mx - mn) * s) / 32768);
    end
    return bound_delay(mx);
  endfunction

  task automatic advance_motor(logic k, logic [15:0] frac);
    int target, diff, h;
    if (k == KIND_MOVE) begin
      if (!moving_q) begin
        target = int'((32'(frac) * 32'(cfg_spr)) >> 16);
        diff = target - int'(pos_q);
        h = int'((32'(cfg_spr) + 1) >> 1);
        if (h == 0) h = 1;
        if (diff <= -h) diff = diff + int'(cfg_spr);
        else if (diff >= h) diff = diff - int'(cfg_spr);
        pos_q = target[15:0];
        dir_q = (diff > 0) ? 1'b0 : 1'b1;
        en_q = 1'b1;
        total_q = (diff < 0) ? 16'(-diff) : 16'(diff);
        index_q = '0;
        if (total_q != 0) begin
          moving_q = 1'b1;
          pulse_q = 1'b1;
          half_ticks = '0;
          ticks_left = step_delay(index_q);
        end else begin
          pulse_q = 1'b0;
          half_ticks = '0;
          ticks_left = '0;
        end
      end
    end else if (moving_q) begin
      if (ticks_left > 1) begin
        ticks_left--;
        half_ticks++;
      end else if (pulse_q) begin
        pulse_q = 1'b0;
        half_ticks = '0;
        ticks_left = step_delay(index_q);
      end else begin
        index_q++;
        if (index_q >= total_q) begin
          moving_q = 1'b0;
          half_ticks = '0;
          ticks_left = '0;
        end else begin
          pulse_q = 1'b1;
          half_ticks = '0;
          ticks_left = step_delay(index_q);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    motor_state_t got, want;
    if (rst) begin
      cfg_spr = RESET_STEPS_PER_REV;
      cfg_max = RESET_MAX_DELAY;
      cfg_min = RESET_MIN_DELAY;
      cfg_mode = RESET_RAMP_MODE;
      {pos_q, total_q, index_q, half_ticks, ticks_left} = '0;
      {pulse_q, dir_q, en_q, moving_q} = '0;
      expected_states.delete();
    end else begin
      if (write_en) begin
        case (write_index)
          REG_STEPS_PER_REV: cfg_spr = write_data;
          REG_MAX_DELAY:     cfg_max = write_data;
          REG_MIN_DELAY:     cfg_min = write_data;
          REG_RAMP_MODE:     cfg_mode = write_data[1:0];
        endcase
      end
      if (out_valid && !out_stall) begin
        got = '{pulse_level, direction_level, enable_level, busy_res, position};
        if (expected_states.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          fail_count++;
        end else begin
          want = expected_states.pop_front();
          if (got !== want) begin
            $display("%0t: pulse/dir/en/busy/pos expected %b %b %b %b %0d actual %b %b %b %b %0d",
                     $time, want.pulse, want.dir, want.en, want.busy, want.pos,
                     got.pulse, got.dir, got.en, got.busy, got.pos);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        advance_motor(kind, target_fraction);
        expected_states.push_back('{pulse_q, dir_q, en_q, moving_q, pos_q});
      end
    end
    pending_results = expected_states.size();
    motion_active = moving_q;
  end

  initial begin
    fail_count = 0;
    pending_results = 0;
    motion_active = 1'b0;
  end
endmodule

// ===== test/tb_stepper_move_ramp_pulser_core.sv =====
module tb_stepper_move_ramp_pulser_core;
  timeunit 1ns;
  timeprecision 1ps;
  import smrp_pkg::*;

  localparam int CYCLE_LIMIT = 4000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        write_en = 1'b0;
  logic [1:0]  write_index = '0;
  logic [15:0] write_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        kind = KIND_TICK;
  logic [15:0] target_fraction = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        pulse_level, direction_level, enable_level, busy_res;
  logic [15:0] position;
  int          fail_count, pending_results;
  logic        motion_active;
  int          gap_pct = 0;
  int          stall_pct = 0;
  int          cycles = 0;
  logic        narrow_moves = 1'b0;

  stepper_move_ramp_pulser_core u_dut (.*);

  stepper_move_ramp_pulser_checker u_chk (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= rst ? 1'b0 : ($urandom_range(99) < stall_pct);
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_request(logic k, logic [15:0] frac);
    if ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    in_valid <= 1'b1;
    kind <= k;
    target_fraction <= frac;
    do @(posedge clk); while (in_stall);
  endtask

  // wait for every result and send ticks until the motor is still
  task automatic settle();
    in_valid <= 1'b0;
    forever begin
      @(negedge clk);
      if (pending_results == 0 && !motion_active) break;
      if (pending_results == 0) begin
        @(posedge clk);
        send_request(KIND_TICK, 16'($urandom));
        in_valid <= 1'b0;
      end
    end
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    write_en <= 1'b1;
    write_index <= idx;
    write_data <= val;
    @(posedge clk);
    write_en <= 1'b0;
  endtask

  task automatic setup_motor(logic [15:0] spr, logic [15:0] mx, logic [15:0] mn,
                             logic [1:0] mode);
    settle();
    @(posedge clk);
    write_reg(REG_STEPS_PER_REV, spr);
    write_reg(REG_MAX_DELAY, mx);
    write_reg(REG_MIN_DELAY, mn);
    write_reg(REG_RAMP_MODE, mode);
    narrow_moves = (spr > 100);
  endtask

  task automatic random_requests(int n);
    logic [15:0] frac;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) begin
        frac = 16'($urandom);
        if (narrow_moves) frac = $urandom_range(1) ? 16'($urandom_range(3))
                                                   : 16'hffff - 16'($urandom_range(3));
        send_request(KIND_MOVE, frac);
      end else begin
        send_request(KIND_TICK, 16'($urandom));
      end
    end
  endtask

  task automatic random_phase(int sets);
    logic [15:0] mx, mn;
    for (int s = 0; s < sets; s++) begin
      mx = 16'($urandom_range(1, 4));
      mn = 16'($urandom_range(1, 4));
      setup_motor(16'($urandom_range(2, 40)), mx, mn, 2'($urandom_range(3)));
      random_requests(70);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // defaults: idle tick and a zero-length move
    send_request(KIND_TICK, 16'hffff);
    send_request(KIND_MOVE, 16'h0000);
    setup_motor(16'd0, 16'd3, 16'd2, MODE_SPARE);
    send_request(KIND_MOVE, 16'hffff);
    setup_motor(16'd12, 16'd1, 16'd4, MODE_LINEAR);
    send_request(KIND_MOVE, 16'hffff);
    send_request(KIND_MOVE, 16'h8000);
    repeat (6) send_request(KIND_TICK, 16'h0000);
    setup_motor(16'd9, 16'd5, 16'd1, MODE_SINE);
    send_request(KIND_MOVE, 16'h7fff);
    repeat (8) send_request(KIND_TICK, 16'h5555);
    setup_motor(16'd2, 16'd1, 16'd1, MODE_CONSTANT);
    send_request(KIND_MOVE, 16'h8000);
    send_request(KIND_MOVE, 16'h0000);
    setup_motor(16'hffff, 16'd1, 16'd1, MODE_LINEAR);
    send_request(KIND_MOVE, 16'hffff);
    random_requests(40);

    gap_pct = 7;
    stall_pct = 75;
    random_phase(3);
    gap_pct = 75;
    stall_pct = 7;
    random_phase(3);
    gap_pct = 0;
    stall_pct = 0;
    random_phase(2);

    setup_motor(16'd4, 16'd1, 16'hffff, MODE_CONSTANT);
    send_request(KIND_MOVE, 16'hc000);
    repeat (10) send_request(KIND_TICK, 16'h0000);
    setup_motor(16'd4, 16'd30, 16'd1, MODE_LINEAR);
    send_request(KIND_MOVE, 16'h4000);
    settle();

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

// ===== files.f =====
rtl/smrp_pkg.sv
rtl/smrp_div.sv
rtl/smrp_dp.sv
rtl/smrp_ctrl.sv
rtl/stepper_move_ramp_pulser_core.sv
test/stepper_move_ramp_pulser_checker.sv
test/tb_stepper_move_ramp_pulser_core.sv
